@@ design/sld_pkg.sv @@
// shared constants and types for the scope latch display writer
package sld_pkg;

  // display grid
  localparam int COLUMNS = 16;
  localparam int ROWS    = 4;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int IDX_W   = $clog2(CELLS);

  // field widths
  localparam int COL_W  = 4;
  localparam int ROW_W  = 2;
  localparam int WORD_W = 16;
  localparam int CUR_W  = 8;

  // latch word decoding
  localparam int                HOME_BIT_POS = 15;
  localparam logic [WORD_W-1:0] NEWLINE_WORD = 16'hD555;

  // request kinds carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // cursor decode of one request
  typedef struct packed {
    logic             is_char;
    logic             in_grid;
    logic [IDX_W-1:0] idx;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } lookup_t;

  // one redraw result
  typedef struct packed {
    logic [WORD_W-1:0] pattern;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } result_t;

endpackage

@@ design/sld_cursor.sv @@
// cursor counters and decode of the latch word into a cache lookup
module sld_cursor
  import sld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd,
  input  logic [WORD_W-1:0] word,
  output lookup_t           lk
);

  logic [CUR_W-1:0] cursor_column;
  logic [CUR_W-1:0] cursor_row;
  logic             is_home;
  logic             is_newline;
  logic [IDX_W-1:0] flat_idx;

  // classify the word
  assign is_home    = !word[HOME_BIT_POS];
  assign is_newline = (word == NEWLINE_WORD);

  // cell index and grid check from the current cursor
  assign flat_idx = IDX_W'(cursor_row * CUR_W'(COLUMNS) + cursor_column);

  always_comb begin
    lk.is_char = (cmd == CMD_WRITE) && !is_home && !is_newline;
    lk.in_grid = (cursor_column < CUR_W'(COLUMNS)) && (cursor_row < CUR_W'(ROWS));
    lk.idx     = flat_idx;
    lk.col     = cursor_column[COL_W-1:0];
    lk.row     = cursor_row[ROW_W-1:0];
  end

  // cursor update, 8-bit wrapping counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else if (accept && cmd == CMD_WRITE) begin
      if (is_home) begin
        cursor_column <= '0;
        cursor_row    <= '0;
      end else if (is_newline) begin
        cursor_column <= '0;
        cursor_row    <= cursor_row + CUR_W'(1);
      end else begin
        cursor_column <= cursor_column + CUR_W'(1);
      end
    end
  end

endmodule

@@ design/sld_cache.sv @@
// request register, pattern cache memory with valid bits, and redraw compare
module sld_cache
  import sld_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              cmd,
  input  logic [WORD_W-1:0] word,
  input  lookup_t           lk,
  input  logic              advance,
  output logic              s1_valid,
  output logic              emit,
  output result_t           res
);

  logic [WORD_W-1:0] cache_mem [CELLS];
  logic [CELLS-1:0]  cell_valid;

  logic              s1_cmd;
  logic [WORD_W-1:0] s1_word;
  lookup_t           s1_lk;
  logic [WORD_W-1:0] rd_data;
  logic              fwd_hit;
  logic [WORD_W-1:0] fwd_data;

  logic [WORD_W-1:0] cached;
  logic              wr_en;
  logic              clear_en;

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_word <= word;
      s1_lk   <= lk;
    end
  end

  // cache memory, read-before-write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cache_mem[s1_lk.idx] <= s1_word;
    end
    if (accept) begin
      rd_data <= cache_mem[lk.idx];
    end
  end

  // bypass for a write to the same cell in the read cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= wr_en && (s1_lk.idx == lk.idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= s1_word;
    end
  end

  // valid bits, cleared at once by a clear request
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= '0;
    end else if (clear_en) begin
      cell_valid <= '0;
    end else if (wr_en) begin
      cell_valid[s1_lk.idx] <= 1'b1;
    end
  end

  // redraw decision
  assign cached   = fwd_hit ? fwd_data : rd_data;
  assign emit     = s1_valid && (s1_cmd == CMD_WRITE) && s1_lk.is_char && s1_lk.in_grid &&
                    (!cell_valid[s1_lk.idx] || (cached != s1_word));
  assign wr_en    = advance && emit;
  assign clear_en = advance && s1_valid && (s1_cmd == CMD_CLEAR);

  always_comb begin
    res.pattern = s1_word;
    res.row     = s1_lk.row;
    res.col     = s1_lk.col;
  end

  // checks
  a_write_needs_char: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && s1_cmd == CMD_WRITE && s1_lk.in_grid))
    else $error("cache write without a character request in the grid");

  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> cell_valid[$past(s1_lk.idx)])
    else $error("cache write did not mark its cell valid");

  a_bypass_taken: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en && s1_lk.idx == lk.idx) |=> fwd_hit)
    else $error("same-cell write missed by the bypass");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (rst)
    clear_en |-> !wr_en)
    else $error("cache write during a clear request");

endmodule

@@ design/scope_latch_display_writer.sv @@
// top level of the scope latch display writer
// Takes one request per cycle: a 16-bit latch word (tuser 0) or a cache clear
// (tuser 1). Home and new-line words move the cursor; other words are
// characters that produce one redraw result (column, row, pattern) when the
// cursor is in the 16x4 grid and the cell's cached pattern is invalid or
// different. Each request is held in the request register, where the registered
// read of the 64-entry cache memory is compared; its redraw result then goes to
// the output register. A new request is taken every cycle unless the output
// stalls. Reset clears the cursor and the cell valid bits at once, with no
// clearing pass.
module scope_latch_display_writer
  import sld_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] latch_word
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [3:0] cell_column, [5:4] cell_row, [21:6] cell_pattern
);

  lookup_t lk;
  result_t res;
  logic    accept;
  logic    advance;
  logic    s1_valid;
  logic    emit;

  // handshake
  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;

  sld_cursor u_cursor (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (s_tuser[0]),
    .word   (s_tdata),
    .lk     (lk)
  );

  sld_cache u_cache (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .cmd      (s_tuser[0]),
    .word     (s_tdata),
    .lk       (lk),
    .advance  (advance),
    .s1_valid (s1_valid),
    .emit     (emit),
    .res      (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_tdata <= {2'b00, res.pattern, res.row, res.col};
    end
  end

endmodule
